@@ hw/rtl/mpwm_pkg.sv @@
// Shared constants, types and decode helpers for the motor PWM submodule register block.
// Used by motor_pwm_submodule_regs; depends on nothing else.
package mpwm_pkg;

	localparam int NUM_SM      = 4;
	localparam int SM_W        = $clog2(NUM_SM);
	localparam int REG_BYTES   = 512;
	localparam int REG_WORDS   = REG_BYTES / 2;
	localparam int OFF_W       = 9;
	localparam int WORD_W      = OFF_W - 1;
	localparam int R_W         = 7;
	localparam int STRIDE      = 'h60;
	localparam int NCMP        = 6;
	localparam int CMP_W       = $clog2(NCMP);

	localparam logic [OFF_W-1:0] SM_SPAN   = OFF_W'(NUM_SM * STRIDE);
	localparam logic [OFF_W-1:0] OFF_MCTRL = 9'h188;
	localparam logic [OFF_W-1:0] OFF_LAST  = OFF_W'(REG_BYTES - 2);

	localparam logic [R_W-1:0] R_CNT   = 7'h00;
	localparam logic [R_W-1:0] R_INIT  = 7'h02;
	localparam logic [R_W-1:0] R_CTRL  = 7'h06;
	localparam logic [R_W-1:0] R_VAL0  = 7'h0A;
	localparam logic [R_W-1:0] R_VAL1  = 7'h0E;
	localparam logic [R_W-1:0] R_VAL2  = 7'h12;
	localparam logic [R_W-1:0] R_VAL3  = 7'h16;
	localparam logic [R_W-1:0] R_VAL4  = 7'h1A;
	localparam logic [R_W-1:0] R_VAL5  = 7'h1E;
	localparam logic [R_W-1:0] R_STS   = 7'h24;
	localparam logic [R_W-1:0] R_INTEN = 7'h26;
	localparam logic [R_W-1:0] R_TCTRL = 7'h2A;
	localparam logic [R_W-1:0] R_DT0   = 7'h30;
	localparam logic [R_W-1:0] R_DT1   = 7'h32;

	localparam int BIT_RF    = 12;
	localparam int LDOK_LSB  = 0;
	localparam int CLDOK_LSB = 4;
	localparam int RUN_LSB   = 8;
	localparam int PRSC_LSB  = 4;
	localparam int PRSC_W    = 3;

	localparam logic [15:0] CMP_MASK   = 16'h003F;
	localparam logic [15:0] LDOK_MASK  = 16'h000F;
	localparam logic [15:0] CTRL_RST   = 16'h0400;
	localparam logic [15:0] DTCNT_RST  = 16'h07FF;
	localparam logic [9:0]  DUTY_SCALE = 10'd1000;

	localparam int DIV_N_W   = 16 + 10;
	localparam int DIV_CNT_W = $clog2(DIV_N_W);

	localparam int IN_TDATA_W  = 32;
	localparam int OUT_TDATA_W = 96;

	typedef enum logic [1:0] {
		FUNC_READ  = 2'd0,
		FUNC_WRITE = 2'd1,
		FUNC_TICK  = 2'd2
	} func_t;

	typedef enum logic [3:0] {
		S_IDLE, S_EXEC, S_RD, S_MC_LOAD, S_MC_RAM, S_MC_START, S_MC_RUN,
		S_MC_NEXT, S_TICK, S_TK_NEXT, S_DIV, S_DONE
	} state_t;

	typedef enum logic [3:0] {
		MK_NONE, MK_INIT, MK_CTRL, MK_VAL1, MK_VAL2, MK_VAL3, MK_STS, MK_INTEN, MK_TCTRL
	} mk_t;

	typedef struct packed {
		logic            in_sub;
		logic [SM_W-1:0] sm;
		logic [R_W-1:0]  r;
	} sub_loc_t;

	typedef struct packed {
		logic             hit;
		logic [CMP_W-1:0] idx;
	} cmp_loc_t;

	function automatic sub_loc_t sub_loc(input logic [OFF_W-1:0] off);
		sub_loc_t l;
		logic [OFF_W-1:0] base;
		l.in_sub = off < SM_SPAN;
		l.sm = '0;
		base = '0;
		for (int i = 1; i < NUM_SM; i++) begin
			if (off >= OFF_W'(i * STRIDE)) begin
				l.sm = SM_W'(i);
				base = OFF_W'(i * STRIDE);
			end
		end
		l.r = R_W'(off - base);
		return l;
	endfunction

	function automatic logic [OFF_W-1:0] sm_base(input logic [SM_W-1:0] sm);
		return OFF_W'(OFF_W'(sm) * OFF_W'(STRIDE));
	endfunction

	function automatic mk_t mir_kind(input logic [R_W-1:0] r);
		mk_t k;
		case (r)
			R_INIT:  k = MK_INIT;
			R_CTRL:  k = MK_CTRL;
			R_VAL1:  k = MK_VAL1;
			R_VAL2:  k = MK_VAL2;
			R_VAL3:  k = MK_VAL3;
			R_STS:   k = MK_STS;
			R_INTEN: k = MK_INTEN;
			R_TCTRL: k = MK_TCTRL;
			default: k = MK_NONE;
		endcase
		return k;
	endfunction

	function automatic cmp_loc_t cmp_loc(input logic [R_W-1:0] r);
		cmp_loc_t c;
		c.hit = 1'b1;
		case (r)
			R_VAL0:  c.idx = CMP_W'(0);
			R_VAL1:  c.idx = CMP_W'(1);
			R_VAL2:  c.idx = CMP_W'(2);
			R_VAL3:  c.idx = CMP_W'(3);
			R_VAL4:  c.idx = CMP_W'(4);
			R_VAL5:  c.idx = CMP_W'(5);
			default: begin
				c.hit = 1'b0;
				c.idx = '0;
			end
		endcase
		return c;
	endfunction

	// Reset contents of a word held in the RAM.
	function automatic logic [15:0] rst_word(input logic [WORD_W-1:0] w);
		sub_loc_t l;
		l = sub_loc({w, 1'b0});
		return (l.in_sub && (l.r == R_DT0 || l.r == R_DT1)) ? DTCNT_RST : 16'h0000;
	endfunction

	function automatic logic irq_fn(input logic [15:0] sts, input logic [15:0] en);
		return (sts[BIT_RF] & en[BIT_RF]) | (|(sts & en & CMP_MASK));
	endfunction

	// Compare registers that a commit copies into the RAM: VAL0, VAL4 and VAL5.
	function automatic logic [R_W-1:0] ld_r(input logic [1:0] k);
		logic [R_W-1:0] r;
		case (k)
			2'd0:    r = R_VAL0;
			2'd1:    r = R_VAL4;
			default: r = R_VAL5;
		endcase
		return r;
	endfunction

	function automatic logic [CMP_W-1:0] ld_ci(input logic [1:0] k);
		logic [CMP_W-1:0] c;
		case (k)
			2'd0:    c = CMP_W'(0);
			2'd1:    c = CMP_W'(4);
			default: c = CMP_W'(5);
		endcase
		return c;
	endfunction

endpackage

@@ hw/rtl/mpwm_ram.sv @@
// Generic simple dual-port RAM with registered read data.
// No dependencies.
module mpwm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ hw/rtl/motor_pwm_submodule_regs.sv @@
// Every item runs through the sequencer: a read, a plain write, a tick or an MCTRL write; the block
// takes no new item until the last one has finished. Ticks and MCTRL writes walk the submodules,
// and a reload, a commit or a start uses the shared 26-step divider.
// Reset (asynchronous, active low) restores every register to its documented value at once;
// RAM words carry valid bits, so no clearing pass is needed and items are taken right away.
// Top level of the motor PWM submodule register block; uses mpwm_pkg and mpwm_ram.
module motor_pwm_submodule_regs (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic                                 cfg_wdata,   // clock_present
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [mpwm_pkg::IN_TDATA_W-1:0]      s_tdata,     // byte_offset, write_data, pad
	input  logic [1:0]                           s_tuser,     // func
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// read_data, irq_lines, trigger_pulses, duty_sub0..3, running_mask, pad
	output logic [mpwm_pkg::OUT_TDATA_W-1:0]     m_tdata
);
	import mpwm_pkg::*;

	// Sequencer and item registers.
	state_t              state_q, state_d, ret_q, div_ret;
	logic [1:0]          func_q;
	logic [OFF_W-1:0]    off_q;
	logic [15:0]         wd_q;
	logic [SM_W-1:0]     sm_q;
	logic [1:0]          k_q;
	logic                clk_pres_q;

	// Architectural registers that the arithmetic needs are kept in flops; all other words
	// of the register map live in the RAM.
	logic [15:0] init_q  [NUM_SM];
	logic [15:0] ctrl_q  [NUM_SM];
	logic [15:0] val1_q  [NUM_SM];
	logic [15:0] val2_q  [NUM_SM];
	logic [15:0] val3_q  [NUM_SM];
	logic [15:0] sts_q   [NUM_SM];
	logic [15:0] inten_q [NUM_SM];
	logic [15:0] tctrl_q [NUM_SM];
	logic [15:0] mctrl_q;
	logic [15:0] shadow_init_q [NUM_SM];
	logic [15:0] shadow_cmp_q  [NUM_SM][NCMP];
	logic [15:0] duty_q  [NUM_SM];
	logic [16:0] pe_q    [NUM_SM];
	logic [6:0]  pc_q    [NUM_SM];
	logic [PRSC_W-1:0] cps_q [NUM_SM];
	logic [16:0] cp_q    [NUM_SM];
	logic [NUM_SM-1:0] run_q;
	logic [NUM_SM-1:0] irq_q;
	logic [NUM_SM-1:0] trig_q;
	logic [15:0]       rd_q;
	logic [REG_WORDS-1:0] vld_q;

	// Shared divider.
	logic [DIV_N_W-1:0]   div_num_q;
	logic [15:0]          div_rem_q;
	logic [15:0]          div_den_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic                 div_go;

	// Output register.
	logic                   m_valid_q;
	logic [OUT_TDATA_W-1:0] out_q;

	// RAM port.
	logic              ram_we, ram_re;
	logic [WORD_W-1:0] ram_waddr;
	logic [15:0]       ram_wdata, ram_rdata;

	// Decode of the held item.
	sub_loc_t          dec, wdec;
	cmp_loc_t          cl;
	mk_t               wkind;
	logic [WORD_W-1:0] word;
	logic              oor, mctrl_word, plain_ram, cnt_rd;
	logic              wr_init, wr_sts, wr_cnt, wr_inten, wr_mctrl, wr_plain;

	// Values of the submodule in hand.
	logic [SM_W-1:0] cur_sm;
	logic [15:0]     c_init, c_mod, c_on, c_sts, c_inten, c_tctrl, c_down, cnt_val, mir_val;
	logic [15:0]     sts_rf;
	logic [16:0]     c_cp, pe_nx;
	logic [7:0]      pc_nx;
	logic            pre_hit, per_hit, reload;
	logic            ld_sel, run_new, run_old, start_en;
	logic [OFF_W-1:0]  ld_byte;
	logic [WORD_W-1:0] ld_word;

	// Divider step.
	logic [16:0]        rem_sh;
	logic               div_ge;
	logic [15:0]        rem_nx;
	logic [DIV_N_W-1:0] num_nx;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_valid_q;
	assign m_tdata  = out_q;

	assign word       = off_q[OFF_W-1:1];
	assign dec        = sub_loc(off_q);
	assign wdec       = sub_loc({word, 1'b0});
	assign cl         = dec.in_sub ? cmp_loc(dec.r) : '0;
	assign wkind      = wdec.in_sub ? mir_kind(wdec.r) : MK_NONE;
	assign oor        = off_q > OFF_LAST;
	assign mctrl_word = (word == OFF_MCTRL[OFF_W-1:1]);
	assign plain_ram  = (wkind == MK_NONE) && !mctrl_word;
	assign cnt_rd     = dec.in_sub && (dec.r == R_CNT);
	assign wr_init    = dec.in_sub && (dec.r == R_INIT);
	assign wr_sts     = dec.in_sub && (dec.r == R_STS);
	assign wr_cnt     = dec.in_sub && (dec.r == R_CNT);
	assign wr_inten   = dec.in_sub && (dec.r == R_INTEN);
	assign wr_mctrl   = (off_q == OFF_MCTRL);
	assign wr_plain   = !wr_init && !cl.hit && !wr_sts && !wr_cnt && !wr_mctrl;

	// While an access is decoded the submodule comes from the address; afterwards the
	// sequencer walks the submodules one by one.
	assign cur_sm  = (state_q == S_EXEC) ? wdec.sm : sm_q;
	assign c_init  = init_q[cur_sm];
	assign c_mod   = val1_q[cur_sm] - c_init + 16'd1;
	assign c_on    = val3_q[cur_sm] - val2_q[cur_sm];
	assign c_sts   = sts_q[cur_sm];
	assign c_inten = inten_q[cur_sm];
	assign c_tctrl = tctrl_q[cur_sm];
	assign c_cp    = cp_q[cur_sm];
	assign c_down  = 16'(c_cp - pe_q[cur_sm]);
	assign cnt_val = (c_cp == 17'd0 || c_mod == 16'd0) ? c_init : c_init + (c_mod - c_down);
	assign sts_rf  = c_sts | (16'd1 << BIT_RF);

	always_comb begin
		case (wkind)
			MK_INIT:  mir_val = c_init;
			MK_CTRL:  mir_val = ctrl_q[cur_sm];
			MK_VAL1:  mir_val = val1_q[cur_sm];
			MK_VAL2:  mir_val = val2_q[cur_sm];
			MK_VAL3:  mir_val = val3_q[cur_sm];
			MK_STS:   mir_val = c_sts;
			MK_INTEN: mir_val = c_inten;
			MK_TCTRL: mir_val = c_tctrl;
			default:  mir_val = mctrl_q;
		endcase
	end

	// Commit and run decisions for the submodule in hand on an MCTRL write.
	assign ld_sel  = wd_q[4'(LDOK_LSB) + 4'(sm_q)] & ~wd_q[4'(CLDOK_LSB) + 4'(sm_q)];
	assign run_new = wd_q[4'(RUN_LSB) + 4'(sm_q)];
	assign run_old = mctrl_q[4'(RUN_LSB) + 4'(sm_q)];
	assign start_en = ((state_q == S_MC_START) && run_new) ||
	                  ((state_q == S_MC_RUN) && run_new && !run_old);
	assign ld_byte = sm_base(sm_q) + OFF_W'(ld_r(k_q));
	assign ld_word = ld_byte[OFF_W-1:1];

	// Prescaler and period counting for one tick.
	assign pc_nx   = {1'b0, pc_q[cur_sm]} + 8'd1;
	assign pre_hit = pc_nx >= (8'd1 << cps_q[cur_sm]);
	assign pe_nx   = pe_q[cur_sm] + 17'd1;
	assign per_hit = pe_nx >= c_cp;
	assign reload  = run_q[cur_sm] && pre_hit && per_hit;

	// Restoring division, one quotient bit per cycle.
	assign rem_sh = {div_rem_q, div_num_q[DIV_N_W-1]};
	assign div_ge = rem_sh >= {1'b0, div_den_q};
	assign rem_nx = div_ge ? 16'(rem_sh - {1'b0, div_den_q}) : rem_sh[15:0];
	assign num_nx = {div_num_q[DIV_N_W-2:0], div_ge};

	mpwm_ram #(.WIDTH(16), .DEPTH(REG_WORDS)) u_regs (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (word),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_waddr = word;
		ram_wdata = wd_q;
		div_go    = 1'b0;
		div_ret   = S_DONE;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_DONE;
				case (func_q)
					FUNC_READ: begin
						if (!oor && !cnt_rd && plain_ram) begin
							ram_re  = 1'b1;
							state_d = S_RD;
						end
					end
					FUNC_WRITE: begin
						if (!oor) begin
							if (wr_mctrl) begin
								state_d = S_MC_LOAD;
							end else if (wr_plain && plain_ram) begin
								ram_we = 1'b1;
							end
						end
					end
					FUNC_TICK: state_d = S_TICK;
					default: ;
				endcase
			end
			S_RD: state_d = S_DONE;
			S_MC_LOAD: state_d = ld_sel ? S_MC_RAM : S_MC_RUN;
			S_MC_RAM: begin
				ram_we    = 1'b1;
				ram_waddr = ld_word;
				ram_wdata = shadow_cmp_q[sm_q][ld_ci(k_q)];
				if (k_q == 2'd2) begin
					div_go  = 1'b1;
					div_ret = S_MC_START;
					state_d = S_DIV;
				end
			end
			S_MC_START: state_d = S_MC_RUN;
			S_MC_RUN: begin
				state_d = S_MC_NEXT;
				if (run_new && !run_old && duty_q[sm_q] == 16'd0) begin
					div_go  = 1'b1;
					div_ret = S_MC_NEXT;
					state_d = S_DIV;
				end
			end
			S_MC_NEXT: state_d = (sm_q == SM_W'(NUM_SM - 1)) ? S_DONE : S_MC_LOAD;
			S_TICK: begin
				state_d = S_TK_NEXT;
				if (reload) begin
					div_go  = 1'b1;
					div_ret = S_TK_NEXT;
					state_d = S_DIV;
				end
			end
			S_TK_NEXT: state_d = (sm_q == SM_W'(NUM_SM - 1)) ? S_DONE : S_TICK;
			S_DIV: begin
				if (div_cnt_q == '0) begin
					state_d = ret_q;
				end
			end
			S_DONE: begin
				if (!m_valid_q || m_tready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ret_q      <= S_DONE;
			func_q     <= '0;
			off_q      <= '0;
			wd_q       <= '0;
			sm_q       <= '0;
			k_q        <= '0;
			clk_pres_q <= 1'b1;
			mctrl_q    <= '0;
			run_q      <= '0;
			irq_q      <= '0;
			trig_q     <= '0;
			rd_q       <= '0;
			vld_q      <= '0;
			div_num_q  <= '0;
			div_rem_q  <= '0;
			div_den_q  <= '0;
			div_cnt_q  <= '0;
			m_valid_q  <= 1'b0;
			out_q      <= '0;
			for (int i = 0; i < NUM_SM; i++) begin
				init_q[i]        <= '0;
				ctrl_q[i]        <= CTRL_RST;
				val1_q[i]        <= '0;
				val2_q[i]        <= '0;
				val3_q[i]        <= '0;
				sts_q[i]         <= '0;
				inten_q[i]       <= '0;
				tctrl_q[i]       <= '0;
				shadow_init_q[i] <= '0;
				duty_q[i]        <= '0;
				pe_q[i]          <= '0;
				pc_q[i]          <= '0;
				cps_q[i]         <= '0;
				cp_q[i]          <= '0;
				for (int j = 0; j < NCMP; j++) begin
					shadow_cmp_q[i][j] <= '0;
				end
			end
		end else begin
			if (cfg_we) begin
				clk_pres_q <= cfg_wdata;
			end

			if (s_tvalid && s_tready) begin
				func_q <= s_tuser;
				off_q  <= s_tdata[OFF_W-1:0];
				wd_q   <= s_tdata[OFF_W+15:OFF_W];
				sm_q   <= '0;
				trig_q <= '0;
				rd_q   <= '0;
			end

			if (ram_we) begin
				vld_q[ram_waddr] <= 1'b1;
			end

			if (div_go) begin
				div_num_q <= DIV_N_W'(c_on) * DIV_N_W'(DUTY_SCALE);
				div_rem_q <= '0;
				div_den_q <= c_mod;
				div_cnt_q <= DIV_CNT_W'(DIV_N_W - 1);
				ret_q     <= div_ret;
			end

			// A start with a zero modulo does nothing; without a clock it only stops.
			if (start_en && c_mod != 16'd0) begin
				if (!clk_pres_q) begin
					run_q[sm_q] <= 1'b0;
				end else begin
					cps_q[sm_q] <= ctrl_q[sm_q][PRSC_LSB +: PRSC_W];
					cp_q[sm_q]  <= {1'b0, c_mod};
					pe_q[sm_q]  <= '0;
					pc_q[sm_q]  <= '0;
					run_q[sm_q] <= 1'b1;
				end
			end

			case (state_q)
				S_EXEC: begin
					if (func_q == FUNC_READ && !oor) begin
						if (cnt_rd) begin
							rd_q <= cnt_val;
						end else if (!plain_ram) begin
							rd_q <= mir_val;
						end
					end
					if (func_q == FUNC_WRITE && !oor) begin
						if (wr_init) begin
							shadow_init_q[dec.sm] <= wd_q;
						end else if (cl.hit) begin
							shadow_cmp_q[dec.sm][cl.idx] <= wd_q;
						end else if (wr_sts) begin
							// Write one to clear.
							sts_q[dec.sm] <= c_sts & ~wd_q;
							irq_q[dec.sm] <= irq_fn(c_sts & ~wd_q, c_inten);
						end else if (wr_plain) begin
							case (wkind)
								MK_INIT:  init_q[wdec.sm]  <= wd_q;
								MK_CTRL:  ctrl_q[wdec.sm]  <= wd_q;
								MK_VAL1:  val1_q[wdec.sm]  <= wd_q;
								MK_VAL2:  val2_q[wdec.sm]  <= wd_q;
								MK_VAL3:  val3_q[wdec.sm]  <= wd_q;
								MK_STS:   sts_q[wdec.sm]   <= wd_q;
								MK_INTEN: inten_q[wdec.sm] <= wd_q;
								MK_TCTRL: tctrl_q[wdec.sm] <= wd_q;
								default: begin
									if (mctrl_word) begin
										mctrl_q <= wd_q;
									end
								end
							endcase
							if (wr_inten) begin
								irq_q[dec.sm] <= irq_fn(c_sts, wd_q);
							end
						end
					end
				end
				S_RD: begin
					rd_q <= vld_q[word] ? ram_rdata : rst_word(word);
				end
				S_MC_LOAD: begin
					k_q <= '0;
					if (ld_sel) begin
						init_q[sm_q] <= shadow_init_q[sm_q];
						val1_q[sm_q] <= shadow_cmp_q[sm_q][1];
						val2_q[sm_q] <= shadow_cmp_q[sm_q][2];
						val3_q[sm_q] <= shadow_cmp_q[sm_q][3];
					end
				end
				S_MC_RAM: begin
					k_q <= k_q + 2'd1;
				end
				S_MC_RUN: begin
					if (!run_new && run_old) begin
						run_q[sm_q] <= 1'b0;
					end
				end
				S_MC_NEXT: begin
					if (sm_q == SM_W'(NUM_SM - 1)) begin
						mctrl_q <= wd_q & ~LDOK_MASK;
					end else begin
						sm_q <= sm_q + SM_W'(1);
					end
				end
				S_TICK: begin
					if (run_q[sm_q]) begin
						if (!pre_hit) begin
							pc_q[sm_q] <= pc_nx[6:0];
						end else begin
							pc_q[sm_q] <= '0;
							if (!per_hit) begin
								pe_q[sm_q] <= pe_nx;
							end else begin
								pe_q[sm_q]  <= '0;
								sts_q[sm_q] <= sts_rf;
								irq_q[sm_q] <= irq_fn(sts_rf, c_inten);
								if ((c_tctrl & CMP_MASK) != 16'd0) begin
									trig_q[sm_q] <= 1'b1;
								end
							end
						end
					end
				end
				S_TK_NEXT: begin
					if (sm_q != SM_W'(NUM_SM - 1)) begin
						sm_q <= sm_q + SM_W'(1);
					end
				end
				S_DIV: begin
					div_rem_q <= rem_nx;
					div_num_q <= num_nx;
					div_cnt_q <= div_cnt_q - DIV_CNT_W'(1);
					if (div_cnt_q == '0) begin
						// A zero modulo gives a duty of zero.
						duty_q[sm_q] <= (div_den_q == 16'd0) ? 16'd0 : num_nx[15:0];
					end
				end
				default: ;
			endcase

			// The result waits here while the next item may already be taken.
			if (state_q == S_DONE && (!m_valid_q || m_tready)) begin
				m_valid_q <= 1'b1;
				out_q <= {4'd0, mctrl_q[RUN_LSB +: NUM_SM], duty_q[3], duty_q[2], duty_q[1],
				          duty_q[0], trig_q, irq_q, rd_q};
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

endmodule
